// File: rtl/core/assert_macros.svh
// assertion macros of the bounded random block, included by its top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk_s, rst_n_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// expression must never be true at a rising clock edge outside reset
`define ASSERT_NEVER(label, clk_s, rst_n_s, expr, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(expr)) else $error(msg);

`endif

// File: rtl/core/pcg_pkg.sv
// types, constants and microcode program of the bounded random block
`default_nettype none

package pcg_pkg;

	localparam int unsigned DataW     = 32;
	localparam int unsigned StateW    = 64;
	localparam int unsigned CfgIdxW   = 8;
	localparam int unsigned PcW       = 4;
	localparam int unsigned MaxDraws  = 64;
	localparam int unsigned DrawCntW  = $clog2(MaxDraws + 1);

	localparam logic [StateW-1:0] LcgMult = 64'h5851_F42D_4C95_7F2D;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegSeed = 8'd0;
	localparam logic [CfgIdxW-1:0] RegIncr = 8'd1;

	// datapath operations, performed when a step falls through
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH_IN,
		OP_DIV_THR,
		OP_THR_LOAD,
		OP_DRAW,
		OP_STATE_LOAD,
		OP_DIV_VAL,
		OP_OUT_DIV,
		OP_OUT_RAW
	} op_e_t;

	// jump conditions: taken when true, fall through otherwise
	typedef enum logic [2:0] {
		C_NONE,
		C_NOIN,
		C_BZERO,
		C_MUL_BUSY,
		C_DIV_BUSY,
		C_REJECT,
		C_DIV_OR_FULL,
		C_OUT_FULL
	} cond_e_t;

	typedef struct packed {
		op_e_t          op;
		cond_e_t        cond;
		logic [PcW-1:0] tgt_t;
		logic [PcW-1:0] tgt_f;
	} uword_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic bound_zero;
		logic mul_busy;
		logic div_busy;
		logic reject;
		logic out_full;
	} seq_stat_t;

	// control toward the datapath
	typedef struct packed {
		op_e_t op;
		logic  fire;
	} ctl_t;

	// microcode program
	function automatic uword_t ucode(input logic [PcW-1:0] pc);
		uword_t w;
		case (pc)
			4'd0:    w = '{OP_LATCH_IN,   C_NOIN,        4'd0,  4'd1};
			4'd1:    w = '{OP_NOP,        C_BZERO,       4'd8,  4'd2};
			4'd2:    w = '{OP_DIV_THR,    C_NONE,        4'd0,  4'd3};
			4'd3:    w = '{OP_THR_LOAD,   C_DIV_BUSY,    4'd3,  4'd4};
			4'd4:    w = '{OP_DRAW,       C_NONE,        4'd0,  4'd5};
			4'd5:    w = '{OP_STATE_LOAD, C_MUL_BUSY,    4'd5,  4'd6};
			4'd6:    w = '{OP_DIV_VAL,    C_REJECT,      4'd4,  4'd7};
			4'd7:    w = '{OP_OUT_DIV,    C_DIV_OR_FULL, 4'd7,  4'd0};
			4'd8:    w = '{OP_DRAW,       C_NONE,        4'd0,  4'd9};
			4'd9:    w = '{OP_STATE_LOAD, C_MUL_BUSY,    4'd9,  4'd10};
			4'd10:   w = '{OP_OUT_RAW,    C_OUT_FULL,    4'd10, 4'd0};
			default: w = '{OP_NOP,        C_NONE,        4'd0,  4'd0};
		endcase
		return w;
	endfunction

	// xsh-rr output permutation of the state before the advance
	function automatic logic [DataW-1:0] xsh_rr(input logic [StateW-1:0] s);
		logic [StateW-1:0] x;
		logic [DataW-1:0]  xs;
		logic [4:0]        rot;
		x   = ((s >> 18) ^ s) >> 27;
		xs  = x[DataW-1:0];
		rot = s[63:59];
		return (xs >> rot) | (xs << ((5'd0 - rot) & 5'd31));
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcg32_bounded_random.sv
// top level of the bounded pcg32 random number block
// Each input word carries a bound and yields one output word. A bound of zero
// returns the raw 32-bit xsh-rr output. A nonzero bound waits twice on the
// shared bit-serial remainder unit (threshold, then final reduction) and on
// the multiply and state load of the lcg advance; each rejected draw adds
// another advance, at most 63 redraws. The block is ready for the next bound
// the cycle after the result is written, also while that result still waits
// in the output register. Writing the seed register (index 0) loads the state
// with the zero-extended low 32 bits of the seed; index 1 sets the increment;
// other indexes are ignored. The user must write configuration only while the
// block is idle; the block itself does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module pcg32_bounded_random (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pcg_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [pcg_pkg::StateW-1:0]    cfg_data,
	// input stream
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [pcg_pkg::DataW-1:0]     s_axis_tdata,  // [31:0] bound
	// output stream
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [pcg_pkg::DataW-1:0]          m_axis_tdata   // [31:0] value
);

	pcg_pkg::ctl_t       ctl;
	pcg_pkg::seq_stat_t  stat;

	logic [pcg_pkg::StateW-1:0]    state_q;
	logic [pcg_pkg::StateW-1:0]    incr_q;
	logic [pcg_pkg::DataW-1:0]     bound_q;
	logic [pcg_pkg::DataW-1:0]     thr_q;
	logic [pcg_pkg::DataW-1:0]     r_q;
	logic [pcg_pkg::DrawCntW-1:0]  n_q;
	logic                          out_valid_q;
	logic [pcg_pkg::DataW-1:0]     out_value_q;

	logic                          cfg_wr;
	logic                          fire_op_latch;
	logic                          fire_op_draw;
	logic                          fire_op_state;
	logic                          fire_op_thr;
	logic                          fire_op_out_div;
	logic                          fire_op_out_raw;
	logic                          div_start;
	logic [pcg_pkg::DataW-1:0]     div_dividend;
	logic                          div_busy;
	logic [pcg_pkg::DataW-1:0]     div_rem;
	logic                          mul_busy;
	logic [pcg_pkg::StateW-1:0]    mul_prod;

	// sequencer
	pcg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// lcg multiplier
	pcg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fire_op_draw),
		.a      (state_q),
		.inc    (incr_q),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	// remainder unit shared by threshold and final reduction
	pcg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (bound_q),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	// decode of the active operation
	always_comb begin
		fire_op_latch   = ctl.fire && (ctl.op == pcg_pkg::OP_LATCH_IN);
		fire_op_draw    = ctl.fire && (ctl.op == pcg_pkg::OP_DRAW);
		fire_op_state   = ctl.fire && (ctl.op == pcg_pkg::OP_STATE_LOAD);
		fire_op_thr     = ctl.fire && (ctl.op == pcg_pkg::OP_THR_LOAD);
		fire_op_out_div = ctl.fire && (ctl.op == pcg_pkg::OP_OUT_DIV);
		fire_op_out_raw = ctl.fire && (ctl.op == pcg_pkg::OP_OUT_RAW);
		div_start       = ctl.fire && ((ctl.op == pcg_pkg::OP_DIV_THR) ||
		                               (ctl.op == pcg_pkg::OP_DIV_VAL));
		div_dividend    = (ctl.op == pcg_pkg::OP_DIV_THR) ? (32'd0 - bound_q) : r_q;
		cfg_wr          = cfg_valid && cfg_ready;
	end

	// status toward the sequencer
	always_comb begin
		stat.in_valid   = s_axis_tvalid;
		stat.bound_zero = (bound_q == '0);
		stat.mul_busy   = mul_busy;
		stat.div_busy   = div_busy;
		stat.reject     = (r_q < thr_q) &&
		                  (n_q < pcg_pkg::DrawCntW'(pcg_pkg::MaxDraws));
		stat.out_full   = out_valid_q && !m_axis_tready;
	end

	// generator state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			incr_q  <= 64'd1;
		end else begin
			if (cfg_wr && (cfg_index == pcg_pkg::RegSeed))
				state_q <= {32'd0, cfg_data[31:0]};
			else if (fire_op_state)
				state_q <= mul_prod;
			if (cfg_wr && (cfg_index == pcg_pkg::RegIncr))
				incr_q <= cfg_data;
		end
	end

	// draw counter and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_op_latch)
				n_q <= '0;
			else if (fire_op_draw)
				n_q <= n_q + pcg_pkg::DrawCntW'(1);
			if (m_axis_tvalid && m_axis_tready)
				out_valid_q <= 1'b0;
			if (fire_op_out_div || fire_op_out_raw)
				out_valid_q <= 1'b1;
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (fire_op_latch)
			bound_q <= s_axis_tdata;
		if (fire_op_thr)
			thr_q <= div_rem;
		if (fire_op_draw)
			r_q <= pcg_pkg::xsh_rr(state_q);
		if (fire_op_out_div)
			out_value_q <= div_rem;
		else if (fire_op_out_raw)
			out_value_q <= r_q;
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (ctl.op == pcg_pkg::OP_LATCH_IN);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;

	// checks
	`ASSERT_CLK(a_rem_below_bound, clk, arst_n, fire_op_out_div |=> (m_axis_tdata < bound_q), "reduced value not below bound")
	`ASSERT_NEVER(a_div_by_zero, clk, arst_n, div_start && (bound_q == '0), "remainder unit started with zero bound")
	`ASSERT_NEVER(a_ready_while_busy, clk, arst_n, s_axis_tready && (mul_busy || div_busy), "input taken while a unit is busy")
	`ASSERT_NEVER(a_draw_limit, clk, arst_n, n_q > pcg_pkg::DrawCntW'(pcg_pkg::MaxDraws), "draw count beyond limit")

endmodule

`default_nettype wire

// File: rtl/core/pcg_mul.sv
// lcg advance: state * multiplier + increment in phases on one 32x32 multiplier
`default_nettype none

module pcg_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pcg_pkg::StateW-1:0]  a,
	input  wire logic [pcg_pkg::StateW-1:0]  inc,
	output logic                             busy,
	output logic [pcg_pkg::StateW-1:0]       prod
);

	logic                        busy_q;
	logic [1:0]                  ph_q;
	logic [pcg_pkg::StateW-1:0]  a_q;
	logic [pcg_pkg::StateW-1:0]  acc_q;
	logic [pcg_pkg::DataW-1:0]   op_a;
	logic [pcg_pkg::DataW-1:0]   op_b;
	logic [pcg_pkg::StateW-1:0]  pp;

	// operand select per phase
	always_comb begin
		case (ph_q)
			2'd1: begin
				op_a = a_q[31:0];
				op_b = pcg_pkg::LcgMult[63:32];
			end
			2'd2: begin
				op_a = a_q[63:32];
				op_b = pcg_pkg::LcgMult[31:0];
			end
			default: begin
				op_a = a_q[31:0];
				op_b = pcg_pkg::LcgMult[31:0];
			end
		endcase
		pp = {32'd0, op_a} * {32'd0, op_b};
	end

	// phase control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 2'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			ph_q   <= 2'd0;
		end else if (busy_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == 2'd3)
				busy_q <= 1'b0;
		end
	end

	// partial product accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
		end else if (busy_q) begin
			case (ph_q)
				2'd0:    acc_q <= pp;
				2'd1:    acc_q[63:32] <= acc_q[63:32] + pp[31:0];
				2'd2:    acc_q[63:32] <= acc_q[63:32] + pp[31:0];
				default: acc_q <= acc_q + inc;
			endcase
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// File: rtl/core/pcg_div.sv
// restoring remainder unit, one quotient bit a cycle
`default_nettype none

module pcg_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pcg_pkg::DataW-1:0]  dividend,
	input  wire logic [pcg_pkg::DataW-1:0]  divisor,
	output logic                            busy,
	output logic [pcg_pkg::DataW-1:0]       rem
);

	logic                       busy_q;
	logic [4:0]                 cnt_q;
	logic [pcg_pkg::DataW-1:0]  dvd_q;
	logic [pcg_pkg::DataW-1:0]  dvs_q;
	logic [pcg_pkg::DataW-1:0]  rem_q;
	logic [pcg_pkg::DataW:0]    rem_sh;
	logic [pcg_pkg::DataW:0]    diff;

	// trial subtract of the shifted partial remainder
	always_comb begin
		rem_sh = {rem_q, dvd_q[pcg_pkg::DataW-1]};
		diff   = rem_sh - {1'b0, dvs_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	// remainder and dividend shift
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[pcg_pkg::DataW-2:0], 1'b0};
			if (!diff[pcg_pkg::DataW])
				rem_q <= diff[pcg_pkg::DataW-1:0];
			else
				rem_q <= rem_sh[pcg_pkg::DataW-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/pcg_seq.sv
// microcode sequencer: step counter, program table and jump conditions
`default_nettype none

module pcg_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pcg_pkg::seq_stat_t stat,
	output pcg_pkg::ctl_t           ctl
);

	logic [pcg_pkg::PcW-1:0] pc_q;
	pcg_pkg::uword_t         w;
	logic                    taken;

	// current control word and its condition
	always_comb begin
		w = pcg_pkg::ucode(pc_q);
		case (w.cond)
			pcg_pkg::C_NONE:        taken = 1'b0;
			pcg_pkg::C_NOIN:        taken = !stat.in_valid;
			pcg_pkg::C_BZERO:       taken = stat.bound_zero;
			pcg_pkg::C_MUL_BUSY:    taken = stat.mul_busy;
			pcg_pkg::C_DIV_BUSY:    taken = stat.div_busy;
			pcg_pkg::C_REJECT:      taken = stat.reject;
			pcg_pkg::C_DIV_OR_FULL: taken = stat.div_busy || stat.out_full;
			pcg_pkg::C_OUT_FULL:    taken = stat.out_full;
			default:                taken = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= '0;
		else
			pc_q <= taken ? w.tgt_t : w.tgt_f;
	end

	assign ctl.op   = w.op;
	assign ctl.fire = !taken;

endmodule

`default_nettype wire

// File: verif/pcg32_bounded_checker.sv
// checker for the bounded pcg32 block: predicts every value word and compares it
`default_nettype none

module pcg32_bounded_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [pcg_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [pcg_pkg::StateW-1:0]    cfg_data,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [pcg_pkg::DataW-1:0]     s_axis_tdata,  // [31:0] bound
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic [pcg_pkg::DataW-1:0]     m_axis_tdata,  // [31:0] value
	output int                                 mismatches,
	output int                                 pending,
	output int                                 values_checked,
	output int                                 redraw_words,
	output int                                 capped_words
);

	localparam logic [63:0] PcgMult   = 64'd6364136223846793005;
	localparam int          DrawLimit = 64;

	typedef struct {
		logic [31:0] bound;
		logic [31:0] value;
	} owed_value_t;

	// generator copy, kept in step with every accepted word
	logic [63:0]  gen_state;
	logic [63:0]  gen_incr;
	owed_value_t  owed_values[$];

	// one lcg step, returns the xsh-rr permutation of the old state
	function automatic logic [31:0] next_pcg_word();
		logic [63:0] old;
		logic [63:0] shifted;
		logic [63:0] doubled;
		logic [4:0]  rot;
		old       = gen_state;
		gen_state = old * PcgMult + gen_incr;
		shifted   = ((old >> 18) ^ old) >> 27;
		rot       = old[63:59];
		// rotate right by doubling the word and shifting
		doubled   = {shifted[31:0], shifted[31:0]} >> rot;
		return doubled[31:0];
	endfunction

	// rejection sampling below a bound, zero bound returns the raw word
	task automatic bounded_pcg_value(input logic [31:0] bound, output logic [31:0] value,
		output int draws);
		logic [31:0] thr;
		logic [31:0] raw;
		raw   = next_pcg_word();
		draws = 1;
		if (bound == 32'd0) begin
			value = raw;
		end else begin
			thr = (~bound + 32'd1) % bound;
			while (draws < DrawLimit && raw < thr) begin
				raw   = next_pcg_word();
				draws = draws + 1;
			end
			value = raw % bound;
		end
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("mismatch @%0t: %s", $time, what);
		mismatches = mismatches + 1;
	endtask

	initial begin
		mismatches     = 0;
		values_checked = 0;
		redraw_words   = 0;
		capped_words   = 0;
		pending        = 0;
	end

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : watch
		owed_value_t owed;
		logic [31:0] value;
		int          draws;
		if (!arst_n) begin
			gen_state = 64'd0;
			gen_incr  = 64'd1;
			owed_values.delete();
			pending  <= 0;
		end else begin
			// register writes, stray indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pcg_pkg::RegSeed: gen_state = {32'd0, cfg_data[31:0]};
					pcg_pkg::RegIncr: gen_incr  = cfg_data;
					default: ;
				endcase
			end
			// compare the delivered word before any new bound is queued
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_values.size() == 0) begin
					report_mismatch($sformatf("value word %h with none expected",
						m_axis_tdata));
				end else begin
					owed = owed_values.pop_front();
					if (m_axis_tdata !== owed.value)
						report_mismatch($sformatf("bound %h: value %h, expected %h",
							owed.bound, m_axis_tdata, owed.value));
					values_checked = values_checked + 1;
				end
			end
			// predict the value for an accepted bound
			if (s_axis_tvalid && s_axis_tready) begin
				bounded_pcg_value(s_axis_tdata, value, draws);
				if (draws > 1)
					redraw_words = redraw_words + 1;
				if (draws == DrawLimit)
					capped_words = capped_words + 1;
				owed.bound = s_axis_tdata;
				owed.value = value;
				owed_values.push_back(owed);
			end
			pending <= owed_values.size();
		end
	end

endmodule

`default_nettype wire

// File: verif/pcg32_bounded_random_tb.sv
// testbench top for the bounded pcg32 block: stimulus, register phases and verdict
`default_nettype none

module pcg32_bounded_random_tb;

	localparam int unsigned RegCount    = 2;
	localparam int          PhaseItems  = 150;
	localparam int          PhaseCount  = 8;
	localparam int          PressCycles = 500;
	localparam int          TailCycles  = 600;
	localparam int          CycleLimit  = 3000000;

	// idling modes, one per phase in turn
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                          clk            = 1'b0;
	logic                          arst_n         = 1'b0;
	logic                          cfg_valid      = 1'b0;
	logic                          cfg_ready;
	logic [pcg_pkg::CfgIdxW-1:0]   cfg_index      = '0;
	logic [pcg_pkg::StateW-1:0]    cfg_data       = '0;
	logic                          s_axis_tvalid  = 1'b0;
	logic                          s_axis_tready;
	logic [pcg_pkg::DataW-1:0]     s_axis_tdata   = '0;  // [31:0] bound
	logic                          m_axis_tvalid;
	logic                          m_axis_tready  = 1'b0;
	logic [pcg_pkg::DataW-1:0]     m_axis_tdata;         // [31:0] value

	int mismatches;
	int pending;
	int values_checked;
	int redraw_words;
	int capped_words;

	int idle_pct  = 0;
	int stall_pct = 0;
	logic press_on = 1'b0;
	int hold_count = 0;
	int cycle_count = 0;
	int bounds_sent = 0;
	int reg_writes = 0;

	pcg32_bounded_random dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pcg32_bounded_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatches     (mismatches),
		.pending        (pending),
		.values_checked (values_checked),
		.redraw_words   (redraw_words),
		.capped_words   (capped_words)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold while pressure is on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_count    <= 0;
		end else if (press_on && hold_count < PressCycles) begin
			m_axis_tready <= 1'b0;
			hold_count    <= hold_count + 1;
		end else begin
			if (!press_on)
				hold_count <= 0;
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// bounds weighted toward the corners of the rejection threshold
	function automatic logic [31:0] pick_bound();
		case ($urandom_range(9))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return $urandom_range(16, 2);
			3:       return 32'h8000_0000 + $urandom_range(8) - 32'd4;
			4:       return 32'hFFFF_FFFF - $urandom_range(8);
			5:       return $urandom_range(1000, 2);
			default: return $urandom;
		endcase
	endfunction

	// one register write, valid stays up for a following write
	task automatic write_reg(input logic [pcg_pkg::CfgIdxW-1:0] idx,
		input logic [pcg_pkg::StateW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes = reg_writes + 1;
	endtask

	// seed, a stray index that must be ignored, then increment
	task automatic set_regs(input logic [pcg_pkg::StateW-1:0] seed_word,
		input logic [pcg_pkg::StateW-1:0] incr_word);
		write_reg(pcg_pkg::RegSeed, seed_word);
		write_reg(pcg_pkg::CfgIdxW'($urandom_range(255, RegCount)), rand64());
		write_reg(pcg_pkg::RegIncr, incr_word);
		cfg_valid <= 1'b0;
	endtask

	// offer one bound word, idling first at random
	task automatic send_bound(input logic [31:0] bound);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= bound;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bounds_sent = bounds_sent + 1;
	endtask

	// wait until every predicted value word has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin idle_pct = 0;  stall_pct <= 0;  end
			IDLE_SENDER:   begin idle_pct = 67; stall_pct <= 0;  end
			IDLE_RECEIVER: begin idle_pct = 0;  stall_pct <= 67; end
			default:       begin idle_pct = 20; stall_pct <= 20; end
		endcase
	endtask

	initial begin : stimulus
		logic [31:0] corner_bounds[13];
		idle_mode_t  mode;
		corner_bounds = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd7, 32'h8000_0000, 32'h8000_0001,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'd0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner bounds from the reset state and increment
		foreach (corner_bounds[i])
			send_bound(corner_bounds[i]);
		drain();

		// stuck generator: zero state and zero increment, seed upper bits ignored
		set_regs(64'hFFFF_FFFF_0000_0000, 64'd0);
		send_bound(32'd3);
		send_bound(32'd0);
		send_bound(32'd1);
		send_bound(32'h8000_0001);
		drain();

		// random phases over a spread of register settings
		for (int p = 0; p < PhaseCount; p++) begin
			case (p)
				0:       set_regs({$urandom, 32'hFFFF_FFFF}, 64'hFFFF_FFFF_FFFF_FFFF);
				1:       set_regs(rand64(), rand64() | 64'd1);
				2:       set_regs(rand64(), rand64() & ~64'd1);
				3:       set_regs(rand64(), 64'd1);
				5:       set_regs(rand64(), 64'd0);
				6:       set_regs({$urandom, 32'd0}, rand64() | 64'd1);
				7:       set_regs(rand64(), {32'd0, $urandom} | 64'd1);
				default: set_regs(rand64(), rand64() | 64'd1);
			endcase
			mode = idle_mode_t'(p % 4);
			set_idle(mode);
			if (p == 4)
				press_on <= 1'b1;
			for (int n = 0; n < PhaseItems; n++)
				send_bound(pick_bound());
			drain();
			press_on <= 1'b0;
		end

		set_idle(IDLE_NONE);
		repeat (TailCycles) @(posedge clk);

		$display("covered %0d bound words across %0d register writes, %0d values checked",
			bounds_sent, reg_writes, values_checked);
		$display("%0d words needed redraws, %0d ran into the draw cap, one long output hold",
			redraw_words, capped_words);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
